// ===== hdl/assert_macros.svh =====
// assertion macros shared by the cache modules
// expects clk and rst in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// condition holds at every clock out of reset
`define LKVC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// consequent holds in the same cycle as the antecedent
`define LKVC_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// consequent holds in the cycle after the antecedent
`define LKVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`else

`define LKVC_ASSERT_ALWAYS(label, cond)
`define LKVC_ASSERT_IMPLIES(label, ante, cons)
`define LKVC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/lkvc_pkg.sv =====
// types, constants and helper functions for the lru key-value cache
// no dependencies; used by the controller, datapath and top level
`default_nettype none

package lkvc_pkg;

  // geometry
  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int RANK_W  = IDX_W;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VAL_W   = 32;
  localparam int CMP_W   = (CAP_W > CNT_W) ? CAP_W + 1 : CNT_W + 1;

  // request kinds
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // value returned by a get that misses
  localparam logic signed [VAL_W-1:0] READ_MISS = '1;

  // request transaction
  typedef struct packed {
    logic                     cmd;
    logic signed [KEY_W-1:0]  lookup_key;
    logic signed [VAL_W-1:0]  store_value;
  } lkvc_req_t;

  // response transaction
  typedef struct packed {
    logic                     hit;
    logic signed [VAL_W-1:0]  read_value;
    logic                     evicted;
  } lkvc_rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic match;
    logic commit;
  } lkvc_ctl_t;

  // capacity register saturated to 1..ENTRIES
  function automatic logic [CNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] c);
    logic [CMP_W-1:0] cw;
    logic [CNT_W-1:0] r;
    cw = CMP_W'(c);
    if (cw == '0) begin
      r = CNT_W'(1);
    end else if (cw > CMP_W'(ENTRIES)) begin
      r = CNT_W'(ENTRIES);
    end else begin
      r = CNT_W'(cw);
    end
    return r;
  endfunction

  // index of the lowest set bit, zero when none is set
  function automatic logic [IDX_W-1:0] lowest_index(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/lkvc_ctrl.sv =====
// request sequencer for the lru key-value cache: idle, match, commit
// depends on lkvc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  output lkvc_ctl_t      ctl
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_COMMIT
  } state_t;

  state_t state;

  // one request in flight; the response register frees the input side
  assign req_ready   = (state == S_IDLE);
  assign ctl.capture = req_valid && req_ready;
  assign ctl.match   = (state == S_MATCH);
  assign ctl.commit  = (state == S_COMMIT) && (!rsp_valid || rsp_ready);

  // state and response valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!rsp_valid || rsp_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (ctl.commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // a new response only ever comes out of the commit step
  `LKVC_ASSERT_IMPLIES(a_rsp_from_commit, $rose(rsp_valid), $past(state) == S_COMMIT)
  // no second request is taken while one is being worked on
  `LKVC_ASSERT_NEXT(a_single_inflight, ctl.capture, !req_ready)
  // match is always followed by commit
  `LKVC_ASSERT_NEXT(a_match_then_commit, state == S_MATCH, state == S_COMMIT)

endmodule

`default_nettype wire

// ===== hdl/lkvc_datapath.sv =====
// entry store, key match, recency ranks and response register of the cache
// depends on lkvc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module lkvc_datapath
  import lkvc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire lkvc_req_t   req,
  input  wire lkvc_ctl_t   ctl,
  output lkvc_rsp_t        rsp
);

  // configuration
  logic [CAP_W-1:0] live_capacity;
  logic [CNT_W-1:0] eff_cap;

  // entry store
  logic [ENTRIES-1:0]             entry_valid;
  logic signed [KEY_W-1:0]        entry_key   [ENTRIES];
  logic signed [VAL_W-1:0]        entry_value [ENTRIES];
  logic [RANK_W-1:0]              entry_rank  [ENTRIES];
  logic [CNT_W-1:0]               live_count;

  // captured request and match results
  lkvc_req_t          req_q;
  logic               m_hit;
  logic [IDX_W-1:0]   m_idx;
  logic [RANK_W-1:0]  m_rank;
  logic               full_q;
  logic [ENTRIES-1:0] drop_q;
  logic [IDX_W-1:0]   slot_q;
  lkvc_rsp_t          rsp_q;

  // match step logic
  logic [ENTRIES-1:0] hit_vec;
  logic [ENTRIES-1:0] drop_vec;
  logic [IDX_W-1:0]   hit_idx;
  logic               full;

  assign eff_cap = eff_capacity(live_capacity);
  assign full    = (live_count >= eff_cap);
  assign hit_idx = lowest_index(hit_vec);
  assign rsp     = rsp_q;

  // parallel key compare and eviction set
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]  = entry_valid[i] && (entry_key[i] == req_q.lookup_key);
      drop_vec[i] = full && entry_valid[i] &&
                    (CNT_W'(entry_rank[i]) >= (eff_cap - CNT_W'(1)));
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      live_capacity <= CAP_W'(16);
    end else if (cfg_we) begin
      live_capacity <= cfg_data;
    end
  end

  // request capture, match registers and response register
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      req_q <= req;
    end
    if (ctl.match) begin
      m_hit  <= |hit_vec;
      m_idx  <= hit_idx;
      m_rank <= entry_rank[hit_idx];
      full_q <= full;
      drop_q <= drop_vec;
      slot_q <= lowest_index(~entry_valid | drop_vec);
    end
    if (ctl.commit) begin
      rsp_q.hit <= m_hit;
      if (req_q.cmd == CMD_GET) begin
        rsp_q.read_value <= m_hit ? entry_value[m_idx] : READ_MISS;
        rsp_q.evicted    <= 1'b0;
      end else begin
        rsp_q.read_value <= '0;
        rsp_q.evicted    <= !m_hit && full_q;
      end
    end
  end

  // key and value storage
  always_ff @(posedge clk) begin
    if (ctl.commit && (req_q.cmd == CMD_PUT)) begin
      if (m_hit) begin
        entry_value[m_idx] <= req_q.store_value;
      end else begin
        entry_key[slot_q]   <= req_q.lookup_key;
        entry_value[slot_q] <= req_q.store_value;
      end
    end
  end

  // valid bits, recency ranks and live count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      live_count  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        entry_rank[i] <= '0;
      end
    end else if (ctl.commit) begin
      if (m_hit) begin
        // touch: newer entries age by one, hit entry becomes newest
        for (int i = 0; i < ENTRIES; i++) begin
          if (entry_valid[i] && (IDX_W'(i) != m_idx) && (entry_rank[i] < m_rank)) begin
            entry_rank[i] <= entry_rank[i] + RANK_W'(1);
          end
        end
        entry_rank[m_idx] <= '0;
      end else if (req_q.cmd == CMD_PUT) begin
        // insert: new entry is newest, drop the oldest, age the rest
        for (int i = 0; i < ENTRIES; i++) begin
          if (IDX_W'(i) == slot_q) begin
            entry_valid[i] <= 1'b1;
            entry_rank[i]  <= '0;
          end else if (drop_q[i]) begin
            entry_valid[i] <= 1'b0;
            entry_rank[i]  <= '0;
          end else if (entry_valid[i]) begin
            entry_rank[i] <= entry_rank[i] + RANK_W'(1);
          end
        end
        live_count <= (full_q ? (eff_cap - CNT_W'(1)) : live_count) + CNT_W'(1);
      end
    end
  end

  // live count tracks the valid bits
  `LKVC_ASSERT_ALWAYS(a_count_matches, $countones(entry_valid) == int'(live_count))
  // keys stay unique across live entries
  `LKVC_ASSERT_ALWAYS(a_keys_unique, $onehot0(hit_vec))
  // an insert never leaves more live entries than the capacity
  `LKVC_ASSERT_NEXT(a_insert_in_cap,
    ctl.commit && (req_q.cmd == CMD_PUT) && !m_hit, live_count <= eff_cap)

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// lru_key_value_cache: fully associative key-value store, lru replacement
// a taken request passes the match and commit steps into the response register
// a new request is taken only once the sequencer is back in idle after commit;
// commit waits while an earlier response is still held
// reset: rst synchronous active high; store empty, capacity 16, no clearing pass
// depends on lkvc_pkg, lkvc_ctrl and lkvc_datapath
`default_nettype none

module lru_key_value_cache
  import lkvc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_data,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire lkvc_req_t        req,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output lkvc_rsp_t             rsp
);

  lkvc_ctl_t ctl;

  // sequencer
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .ctl       (ctl)
  );

  // entry store and response
  lkvc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req),
    .ctl      (ctl),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire
